// ===== rtl/odo_pkg.sv =====
// Shared types, constants and codes for the rolling odometer counter.
`timescale 1ns / 1ps
`default_nettype none

package odo_pkg;

  // Animation frames per decimal digit step.
  localparam int FramesPerDigit = 4;
  localparam int FrameMod       = 10 * FramesPerDigit;
  localparam int FrameW         = $clog2(FrameMod);
  localparam int PhaseW         = (FramesPerDigit > 1) ? $clog2(FramesPerDigit) : 1;

  localparam int CountW   = 10;
  localparam int TileW    = 10;
  localparam int MaxCount = 999;

  typedef enum logic [1:0] {
    ReqTick   = 2'd0,
    ReqTarget = 2'd1,
    ReqSetNow = 2'd2,
    ReqReset  = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    GearNone = 2'd0,
    GearFwd  = 2'd1,
    GearRev  = 2'd2
  } gear_e;

  // Codes equal the two-bit signed direction: up is +1, down is -1.
  typedef enum logic [1:0] {
    DirIdle = 2'b00,
    DirUp   = 2'b01,
    DirDown = 2'b11
  } dir_e;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    req_kind_e         kind;
    logic [CountW-1:0] count;
    bcd_t              digits;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/odo_if.sv =====
// Valid/ready channel interfaces for requests and display results.
`timescale 1ns / 1ps
`default_nettype none

interface odo_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [odo_pkg::CountW-1:0] count_value;

  modport source (output valid, output req_type, output count_value, input ready);
  modport sink   (input valid, input req_type, input count_value, output ready);
endinterface

interface odo_res_if;
  logic                       valid;
  logic                       ready;
  logic [odo_pkg::TileW-1:0]  hundreds_tile;
  logic [odo_pkg::TileW-1:0]  tens_tile;
  logic [odo_pkg::TileW-1:0]  ones_tile;
  logic [odo_pkg::CountW-1:0] shown_count;
  logic signed [1:0]          roll_dir;
  logic                       lock_input;
  logic [1:0]                 gear_cmd;

  modport source (output valid, output hundreds_tile, output tens_tile, output ones_tile,
                  output shown_count, output roll_dir, output lock_input, output gear_cmd,
                  input ready);
  modport sink   (input valid, input hundreds_tile, input tens_tile, input ones_tile,
                  input shown_count, input roll_dir, input lock_input, input gear_cmd,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/odo_front.sv =====
// Front end: accepts requests, saturates the count and splits it into digits.
`timescale 1ns / 1ps
`default_nettype none

module odo_front (
  odo_req_if.sink          req_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output odo_pkg::cmd_t    q_cmd_o
);

  logic [odo_pkg::CountW-1:0] sat_count;
  logic [odo_pkg::CountW-1:0] count;
  logic [15:0]                hund_prod;
  logic [3:0]                 hund;
  logic [odo_pkg::CountW-1:0] rest_full;
  logic [6:0]                 rest;
  logic [14:0]                tens_prod;
  logic [3:0]                 tens;
  logic [6:0]                 ones_full;

  assign req_i.ready = ~q_full_i;
  assign q_push_o    = req_i.valid & ~q_full_i;

  assign sat_count = (req_i.count_value > odo_pkg::CountW'(odo_pkg::MaxCount)) ?
                     odo_pkg::CountW'(odo_pkg::MaxCount) : req_i.count_value;
  assign count     = (odo_pkg::req_kind_e'(req_i.req_type) == odo_pkg::ReqReset) ?
                     '0 : sat_count;

  // Division by 100 and 10 through reciprocal multiplies; exact for counts below 1000.
  assign hund_prod = 16'(count) * 16'd41;
  assign hund      = hund_prod[15:12];
  assign rest_full = count - odo_pkg::CountW'(hund) * odo_pkg::CountW'(100);
  assign rest      = rest_full[6:0];
  assign tens_prod = 15'(rest) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones_full = rest - 7'(tens) * 7'd10;

  assign q_cmd_o.kind        = odo_pkg::req_kind_e'(req_i.req_type);
  assign q_cmd_o.count       = count;
  assign q_cmd_o.digits.hund = hund;
  assign q_cmd_o.digits.tens = tens;
  assign q_cmd_o.digits.ones = ones_full[3:0];

endmodule

`default_nettype wire

// ===== rtl/odo_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module odo_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  odo_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output odo_pkg::cmd_t cmd_o
);

  odo_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/odo_back.sv =====
// Back end: roll state, digit animation frames and the registered result.
`timescale 1ns / 1ps
`default_nettype none

module odo_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [odo_pkg::TileW-1:0] tile_base_i,
  input  logic                      q_valid_i,
  input  odo_pkg::cmd_t             q_cmd_i,
  output logic                      q_pop_o,
  odo_res_if.source                 res_o
);

  localparam int FW = odo_pkg::FrameW;

  function automatic logic [FW-1:0] step_frame(input logic [FW-1:0] f, input logic up);
    logic [FW-1:0] last;
    last = FW'(odo_pkg::FrameMod - 1);
    if (up) begin
      return (f == last) ? '0 : f + FW'(1);
    end
    return (f == '0) ? last : f - FW'(1);
  endfunction

  function automatic logic [FW-1:0] snap_frame(input logic [3:0] d);
    return FW'(32'(d) * odo_pkg::FramesPerDigit);
  endfunction

  function automatic odo_pkg::bcd_t bcd_inc(input odo_pkg::bcd_t b);
    odo_pkg::bcd_t r;
    r = b;
    if (b.ones != 4'd9) begin
      r.ones = b.ones + 4'd1;
    end else begin
      r.ones = 4'd0;
      if (b.tens != 4'd9) begin
        r.tens = b.tens + 4'd1;
      end else begin
        r.tens = 4'd0;
        r.hund = b.hund + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic odo_pkg::bcd_t bcd_dec(input odo_pkg::bcd_t b);
    odo_pkg::bcd_t r;
    r = b;
    if (b.ones != 4'd0) begin
      r.ones = b.ones - 4'd1;
    end else begin
      r.ones = 4'd9;
      if (b.tens != 4'd0) begin
        r.tens = b.tens - 4'd1;
      end else begin
        r.tens = 4'd9;
        r.hund = b.hund - 4'd1;
      end
    end
    return r;
  endfunction

  logic [odo_pkg::CountW-1:0] tgt_q, tgt_d;
  odo_pkg::bcd_t              tgt_bcd_q, tgt_bcd_d;
  logic [odo_pkg::CountW-1:0] disp_q, disp_d;
  odo_pkg::bcd_t              disp_bcd_q, disp_bcd_d;
  odo_pkg::dir_e              dir_q, dir_d;
  logic [odo_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [FW-1:0]              frame_q [3];
  logic [FW-1:0]              frame_d [3];
  odo_pkg::gear_e             gear;
  logic                       load_en;
  logic [odo_pkg::CountW-1:0] load_cnt;
  odo_pkg::bcd_t              load_bcd;
  logic                       up;
  logic                       out_valid_q;

  assign q_pop_o     = q_valid_i & (~out_valid_q | res_o.ready);
  assign res_o.valid = out_valid_q;

  always_comb begin
    tgt_d      = tgt_q;
    tgt_bcd_d  = tgt_bcd_q;
    disp_d     = disp_q;
    disp_bcd_d = disp_bcd_q;
    dir_d      = dir_q;
    phase_d    = phase_q;
    frame_d    = frame_q;
    gear       = odo_pkg::GearNone;
    load_en    = 1'b0;
    load_cnt   = q_cmd_i.count;
    load_bcd   = q_cmd_i.digits;
    up         = (dir_q == odo_pkg::DirUp);

    unique case (q_cmd_i.kind) inside
      odo_pkg::ReqTick: begin
        if (dir_q != odo_pkg::DirIdle) begin
          frame_d[2] = step_frame(frame_q[2], up);
          if (up ? (disp_bcd_q.ones == 4'd9) : (disp_bcd_q.ones == 4'd0)) begin
            frame_d[1] = step_frame(frame_q[1], up);
            if (up ? (disp_bcd_q.tens == 4'd9) : (disp_bcd_q.tens == 4'd0)) begin
              frame_d[0] = step_frame(frame_q[0], up);
            end
          end
          if (phase_q == odo_pkg::PhaseW'(odo_pkg::FramesPerDigit - 1)) begin
            phase_d    = '0;
            disp_d     = up ? disp_q + 1'b1 : disp_q - 1'b1;
            disp_bcd_d = up ? bcd_inc(disp_bcd_q) : bcd_dec(disp_bcd_q);
            if (disp_d == tgt_q) begin
              load_en  = 1'b1;
              load_cnt = tgt_q;
              load_bcd = tgt_bcd_q;
            end
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      odo_pkg::ReqTarget: begin
        tgt_d     = q_cmd_i.count;
        tgt_bcd_d = q_cmd_i.digits;
        if (q_cmd_i.count < disp_q) begin
          dir_d   = odo_pkg::DirDown;
          phase_d = '0;
          gear    = odo_pkg::GearRev;
        end else if (q_cmd_i.count > disp_q) begin
          dir_d   = odo_pkg::DirUp;
          phase_d = '0;
          gear    = odo_pkg::GearFwd;
        end else begin
          load_en = 1'b1;
        end
      end
      odo_pkg::ReqSetNow, odo_pkg::ReqReset: begin
        load_en = 1'b1;
      end
      default: begin
        load_en = 1'b0;
      end
    endcase

    // Direct load: target and shown count agree, digits snap to exact frames.
    if (load_en) begin
      tgt_d      = load_cnt;
      tgt_bcd_d  = load_bcd;
      disp_d     = load_cnt;
      disp_bcd_d = load_bcd;
      dir_d      = odo_pkg::DirIdle;
      frame_d[0] = snap_frame(load_bcd.hund);
      frame_d[1] = snap_frame(load_bcd.tens);
      frame_d[2] = snap_frame(load_bcd.ones);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q       <= '0;
      tgt_bcd_q   <= '0;
      disp_q      <= '0;
      disp_bcd_q  <= '0;
      dir_q       <= odo_pkg::DirIdle;
      phase_q     <= '0;
      frame_q[0]  <= '0;
      frame_q[1]  <= '0;
      frame_q[2]  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        tgt_q      <= tgt_d;
        tgt_bcd_q  <= tgt_bcd_d;
        disp_q     <= disp_d;
        disp_bcd_q <= disp_bcd_d;
        dir_q      <= dir_d;
        phase_q    <= phase_d;
        frame_q    <= frame_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_o.hundreds_tile <= tile_base_i + odo_pkg::TileW'(frame_d[0]);
      res_o.tens_tile     <= tile_base_i + odo_pkg::TileW'(frame_d[1]);
      res_o.ones_tile     <= tile_base_i + odo_pkg::TileW'(frame_d[2]);
      res_o.shown_count   <= disp_d;
      res_o.roll_dir      <= $signed(dir_d);
      res_o.lock_input    <= (dir_d != odo_pkg::DirIdle);
      res_o.gear_cmd      <= gear;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rolling_odometer_counter.sv =====
// Top level of the rolling three-digit odometer display counter.
//
// Usage: requests arrive on req_i as transactions (valid/ready) carrying a
// request type (frame tick, set target with roll, set immediately, reset to
// zero) and a count. Every accepted request produces exactly one result
// transaction on res_o with the three digit tile numbers, the shown count,
// the roll direction, the input lock flag and a one-shot gear command.
// The user must write the tile base register through cfg_we_i/cfg_wdata_i
// only while the block is idle; the block does not enforce it. It is applied
// when results are formed. The front end decodes each accepted request into
// a two-entry queue, and the back end updates the roll state and registers
// the result in the same cycle it pops a command, which it does only while
// the result register is empty or its result is being taken.
// Throughput is one transaction per cycle while the receiver keeps ready high.
// Reset clears the counts, direction, phase and digit frames to zero and the
// tile base to zero. When the receiver stalls, the result register holds,
// the queue fills, and req_i.ready drops once both queue entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module rolling_odometer_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [odo_pkg::TileW-1:0] cfg_wdata_i,
  odo_req_if.sink                   req_i,
  odo_res_if.source                 res_o
);

  logic                      tile_base_q;
  logic [odo_pkg::TileW-1:0] tile_base_r_q;
  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_valid;
  odo_pkg::cmd_t             push_cmd;
  odo_pkg::cmd_t             head_cmd;

  // The tile base register; tile_base_q only marks that it has been written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_base_r_q <= '0;
      tile_base_q   <= 1'b0;
    end else if (cfg_we_i) begin
      tile_base_r_q <= cfg_wdata_i;
      tile_base_q   <= 1'b1;
    end
  end

  // Front end: classify the request and split the saturated count into digits.
  odo_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  // The queue lets the front keep accepting while the result side stalls.
  odo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // Back end: roll sequencing, digit frame animation and result register.
  // Before the first write the base is the reset value of zero either way.
  odo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tile_base_i (tile_base_q ? tile_base_r_q : '0),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_rolling_odometer_counter.sv =====
// Self-checking testbench for the rolling three-digit odometer display counter.
`timescale 1ns / 1ps

module tb_rolling_odometer_counter;
  import odo_pkg::*;

  // Roll state as the display sees it: counts, direction, frame phase and
  // the animation frame offset of each digit.
  typedef struct packed {
    logic [CountW-1:0] target;
    logic [CountW-1:0] shown;
    dir_e              dir;
    logic [4:0]        phase;
    logic [FrameW-1:0] f_hund;
    logic [FrameW-1:0] f_tens;
    logic [FrameW-1:0] f_ones;
    logic              locked;
  } roll_state_t;

  // One request transaction waiting to be driven.
  typedef struct packed {
    req_kind_e         kind;
    logic [CountW-1:0] value;
  } odo_req_t;

  // One display result transaction as it should leave the block.
  typedef struct packed {
    logic [TileW-1:0]  hund;
    logic [TileW-1:0]  tens;
    logic [TileW-1:0]  ones;
    logic [CountW-1:0] shown;
    logic [1:0]        dir;
    logic              lock;
    gear_e             gear;
  } display_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [TileW-1:0] cfg_wdata_i;

  odo_req_if req_bus ();
  odo_res_if res_bus ();

  rolling_odometer_counter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .res_o       (res_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Requests still to be driven, and displays expected from accepted ones.
  odo_req_t    pending_reqs[$];
  display_t    expected_displays[$];

  // Two copies of the roll state: one follows the stimulus as it is planned,
  // the other follows the transactions that the block has actually accepted.
  roll_state_t planned_roll = '0;
  roll_state_t accepted_roll = '0;
  logic [TileW-1:0] tile_base_q = '0;

  int unsigned mismatches = 0;
  int unsigned stim_count = 0;

  // Idling controls. The percentages set how often a burst starts; zero
  // means the side never idles.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic req_fire = 1'b0;

  // Moves one digit's animation frame by one step, wrapping around the
  // ten-digit strip in either direction.
  function automatic logic [FrameW-1:0] step_frame(logic [FrameW-1:0] f, logic up);
    int v;
    v = up ? (int'(f) + 1) % FrameMod : (int'(f) + FrameMod - 1) % FrameMod;
    return FrameW'(v);
  endfunction

  // Loads a count straight into the display: the digits snap to their exact
  // frames, the roll stops and input unlocks. The phase is left alone.
  function automatic roll_state_t settle_count(roll_state_t s, logic [CountW-1:0] c);
    roll_state_t n;
    n        = s;
    n.target = c;
    n.shown  = c;
    n.f_hund = FrameW'(FramesPerDigit * ((c / 100) % 10));
    n.f_tens = FrameW'(FramesPerDigit * ((c / 10) % 10));
    n.f_ones = FrameW'(FramesPerDigit * (c % 10));
    n.dir    = DirIdle;
    n.locked = 1'b0;
    return n;
  endfunction

  // Next roll state for one request, with the gear command it raises.
  function automatic roll_state_t odo_next(roll_state_t s, req_kind_e kind,
                                           logic [CountW-1:0] value, output gear_e gear);
    roll_state_t n;
    logic up;
    logic [CountW-1:0] c;
    n    = s;
    gear = GearNone;
    // Counts past the top of the display saturate.
    c    = (value > MaxCount) ? CountW'(MaxCount) : value;
    case (kind)
      ReqTick: begin
        // A tick with no roll in progress changes nothing.
        if (s.dir != DirIdle) begin
          up = (s.dir == DirUp);
          n.f_ones = step_frame(s.f_ones, up);
          // The tens digit turns over with the ones digit at a carry or
          // borrow, and the hundreds digit with both at a double one.
          if ((up && s.shown % 10 == 9) || (!up && s.shown % 10 == 0)) begin
            n.f_tens = step_frame(s.f_tens, up);
            if ((up && s.shown % 100 == 99) || (!up && s.shown % 100 == 0)) begin
              n.f_hund = step_frame(s.f_hund, up);
            end
          end
          n.phase = s.phase + 5'd1;
          if (int'(n.phase) >= FramesPerDigit) begin
            n.phase = '0;
            n.shown = up ? s.shown + 1'b1 : s.shown - 1'b1;
            if (n.shown == n.target) begin
              n = settle_count(n, n.target);
            end
          end
        end
      end
      ReqTarget: begin
        n.target = c;
        if (c < s.shown) begin
          n.dir    = DirDown;
          n.phase  = '0;
          n.locked = 1'b1;
          gear     = GearRev;
        end else if (c > s.shown) begin
          n.dir    = DirUp;
          n.phase  = '0;
          n.locked = 1'b1;
          gear     = GearFwd;
        end else begin
          // Same as the shown count: the roll stops where it stands.
          n = settle_count(n, c);
        end
      end
      ReqSetNow: n = settle_count(n, c);
      default:   n = settle_count(n, '0);
    endcase
    return n;
  endfunction

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  task automatic check_field(string what, logic [9:0] exp_v, logic [9:0] act_v);
    if (exp_v !== act_v) begin
      report_mismatch(what, exp_v, act_v);
    end
  endtask

  // Sender side: a transaction is held until it is taken, and between
  // transactions the sender may go quiet for a burst of cycles.
  always @(negedge clk_i) begin : drive_requests
    odo_req_t item;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !req_fire) begin
      // Still waiting for the block to take the current transaction.
    end else if (gap_left > 0) begin
      gap_left--;
      req_bus.valid <= 1'b0;
    end else if (pending_reqs.size() > 0 && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap_left = $urandom_range(0, 15);
      req_bus.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      item = pending_reqs.pop_front();
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= item.kind;
      req_bus.count_value <= item.value;
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  // Receiver side: ready drops for bursts of cycles at random.
  always @(negedge clk_i) begin : drive_ready
    if (stall_left > 0) begin
      stall_left--;
      res_bus.ready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 15);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Both handshakes are sampled at the rising edge. An accepted request
  // advances the accepted roll state and queues the display it must produce;
  // an accepted result is compared with the oldest display in that queue.
  always @(posedge clk_i) begin : watch_channels
    gear_e    gear;
    display_t want;
    req_fire <= rst_ni && req_bus.valid && req_bus.ready;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      accepted_roll = odo_next(accepted_roll, req_kind_e'(req_bus.req_type),
                               req_bus.count_value, gear);
      want.hund  = tile_base_q + TileW'(accepted_roll.f_hund);
      want.tens  = tile_base_q + TileW'(accepted_roll.f_tens);
      want.ones  = tile_base_q + TileW'(accepted_roll.f_ones);
      want.shown = accepted_roll.shown;
      want.dir   = accepted_roll.dir;
      want.lock  = accepted_roll.locked;
      want.gear  = gear;
      expected_displays.push_back(want);
    end
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result transaction with no request waiting for it", $realtime);
        end
      end else begin
        want = expected_displays.pop_front();
        check_field("hundreds_tile", want.hund, res_bus.hundreds_tile);
        check_field("tens_tile", want.tens, res_bus.tens_tile);
        check_field("ones_tile", want.ones, res_bus.ones_tile);
        check_field("shown_count", want.shown, res_bus.shown_count);
        // The direction is compared as its raw two-bit code.
        check_field("roll_dir", 10'(want.dir), 10'($unsigned(res_bus.roll_dir)));
        check_field("lock_input", 10'(want.lock), 10'(res_bus.lock_input));
        check_field("gear_cmd", 10'(want.gear), 10'(res_bus.gear_cmd));
      end
    end
  end

  // Queues one request and follows it in the planned roll state, so that
  // later sequences can be built around the count the display will show.
  // Ticks that arrive with no roll in progress do nothing and are not counted.
  task automatic queue_req(req_kind_e kind, logic [CountW-1:0] value);
    gear_e unused_gear;
    if (kind != ReqTick || planned_roll.dir != DirIdle) begin
      stim_count++;
    end
    pending_reqs.push_back({kind, value});
    planned_roll = odo_next(planned_roll, kind, value, unused_gear);
  endtask

  // Returns once every queued request has been taken and every expected
  // display has come back, plus enough cycles for any idling burst on
  // either side to run out.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || req_bus.valid || expected_displays.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // The tile base is written only while nothing is in flight.
  task automatic write_tile_base(logic [TileW-1:0] base);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tile_base_q = base;
  endtask

  // Random traffic. Most of it is well-formed rolls: a target a few counts
  // away followed by the ticks that carry the display there, sometimes cut
  // short so the next target lands mid-roll. The rest is immediate sets,
  // resets, targets equal to the shown count and plain noise.
  task automatic random_traffic(int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    int unsigned ticks;
    int from;
    int dest;
    goal = stim_count + n_items;
    while (stim_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Now and then park the display next to a carry boundary first.
        if ($urandom_range(0, 5) == 0) begin
          queue_req(ReqSetNow, CountW'(100 * $urandom_range(0, 9) + 90 + $urandom_range(0, 19)));
        end
        from = planned_roll.shown;
        dest = $urandom_range(0, 1) ? from + $urandom_range(1, 12) : from - $urandom_range(1, 12);
        if (dest > MaxCount) dest = MaxCount;
        if (dest < 0) dest = 0;
        queue_req(ReqTarget, CountW'(dest));
        ticks = FramesPerDigit * ((dest > from) ? dest - from : from - dest);
        if ($urandom_range(0, 4) == 0) begin
          ticks = $urandom_range(0, ticks);
        end else begin
          ticks += $urandom_range(0, 3);
        end
        repeat (ticks) queue_req(ReqTick, CountW'($urandom_range(0, 1023)));
      end else if (pick < 75) begin
        queue_req(ReqSetNow, CountW'($urandom_range(0, 1023)));
      end else if (pick < 80) begin
        queue_req(ReqReset, CountW'($urandom_range(0, 1023)));
      end else if (pick < 85) begin
        queue_req(ReqTarget, planned_roll.shown);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          queue_req(req_kind_e'($urandom_range(0, 3)), CountW'($urandom_range(0, 1023)));
        end
      end
    end
  endtask

  initial begin : run_test
    logic [TileW-1:0] phase_bases[5];
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = ReqTick;
    req_bus.count_value = '0;
    res_bus.ready       = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_tile_base('0);
    gap_pct   = 20;
    stall_pct = 20;

    // Directed opening: an idle tick, saturated counts, a target equal to
    // the shown count, a short roll down, a roll up across 99 so all three
    // digits turn, a roll down from 100, a target changed mid-roll, a
    // reset during a roll and a roll started from zero.
    queue_req(ReqTick, 10'h3FF);
    queue_req(ReqSetNow, 10'h3FF);
    queue_req(ReqTarget, 10'd1000);
    queue_req(ReqTarget, 10'd998);
    repeat (4) queue_req(ReqTick, 10'h000);
    queue_req(ReqSetNow, 10'd99);
    queue_req(ReqTarget, 10'd100);
    repeat (4) queue_req(ReqTick, 10'h3FF);
    queue_req(ReqTarget, 10'd98);
    repeat (2) queue_req(ReqTick, 10'h155);
    queue_req(ReqTarget, 10'd101);
    repeat (2) queue_req(ReqTick, 10'h2AA);
    queue_req(ReqReset, 10'h3FF);
    queue_req(ReqTarget, 10'd0);
    queue_req(ReqTarget, 10'd1);
    repeat (2) queue_req(ReqTick, 10'h000);
    // The sender holds off here until every display has come back.
    wait_drained();

    // Each phase runs under its own tile base, including both extremes and
    // a base that makes the tile numbers wrap. The last phase has no idling.
    phase_bases[0] = 10'd1023;
    phase_bases[1] = 10'd1000;
    phase_bases[2] = 10'h2AA;
    phase_bases[3] = TileW'($urandom_range(0, 1023));
    phase_bases[4] = 10'd0;
    for (int p = 0; p < 5; p++) begin
      write_tile_base(phase_bases[p]);
      if (p == 4) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 2) * 15;
        stall_pct = $urandom_range(0, 2) * 15;
      end
      random_traffic(380);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake; a correct run ends far sooner.
  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
